>>> design/p2h_pkg.sv
// Shared constants and types for the pixel to hex cell unit.
`timescale 1ns / 1ps

package p2h_pkg;

    localparam int COORD_BITS = 16;
    localparam int MAG_BITS = COORD_BITS - 1;
    localparam int REG_BITS = 12;
    localparam int DIV_BITS = REG_BITS + 2;
    localparam int DIV_STEPS = 3;
    localparam int DIV_STAGES = (MAG_BITS + DIV_STEPS - 1) / DIV_STEPS;
    localparam int PROD_BITS = REG_BITS + DIV_BITS;
    localparam int CFG_INDEX_BITS = 2;

    localparam logic [CFG_INDEX_BITS-1:0] REG_CELL_WIDTH = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_CELL_HEIGHT = CFG_INDEX_BITS'(1);

    localparam logic [REG_BITS-1:0] CELL_WIDTH_RESET = REG_BITS'(26);
    localparam logic [REG_BITS-1:0] CELL_HEIGHT_RESET = REG_BITS'(15);

    typedef struct packed {
        logic                neg;
        logic [MAG_BITS-1:0] acc;
        logic [DIV_BITS-1:0] rem;
    } lane_t;

    typedef struct packed {
        lane_t x;
        lane_t y;
    } div_t;

endpackage

>>> design/p2h_divider.sv
// Pipelined restoring divider for both coordinate lanes, a few quotient bits per stage.
`timescale 1ns / 1ps

module p2h_divider import p2h_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  div_t                in_data,
    input  logic [DIV_BITS-1:0] divisor_x,
    input  logic [DIV_BITS-1:0] divisor_y,
    output logic                out_valid,
    input  logic                out_ready,
    output div_t                out_data
);

    logic [DIV_STAGES:0]   ready;
    logic [DIV_STAGES-1:0] src_valid;
    logic [DIV_STAGES-1:0] valid_reg;
    logic [DIV_STAGES-1:0] valid_next;
    div_t                  src_data  [DIV_STAGES];
    div_t                  data_reg  [DIV_STAGES];
    div_t                  data_next [DIV_STAGES];

    function automatic lane_t div_step(input lane_t l, input logic [DIV_BITS-1:0] d);
        logic [DIV_BITS:0] trial;
        logic [DIV_BITS:0] diff;
        lane_t             r;
        trial = {l.rem, l.acc[MAG_BITS-1]};
        diff  = trial - {1'b0, d};
        r.neg = l.neg;
        if (trial >= {1'b0, d})
        begin
            r.rem = diff[DIV_BITS-1:0];
            r.acc = {l.acc[MAG_BITS-2:0], 1'b1};
        end
        else
        begin
            r.rem = trial[DIV_BITS-1:0];
            r.acc = {l.acc[MAG_BITS-2:0], 1'b0};
        end
        return r;
    endfunction

    function automatic lane_t div_steps(input lane_t l, input logic [DIV_BITS-1:0] d,
                                        input int count);
        lane_t r;
        r = l;
        for (int j = 0; j < DIV_STEPS; j++)
        begin
            if (j < count)
            begin
                r = div_step(r, d);
            end
        end
        return r;
    endfunction

    always_comb
    begin
        src_valid[0] = in_valid;
        src_data[0]  = in_data;
        for (int s = 1; s < DIV_STAGES; s++)
        begin
            src_valid[s] = valid_reg[s-1];
            src_data[s]  = data_reg[s-1];
        end
    end

    always_comb
    begin
        ready[DIV_STAGES] = out_ready;
        for (int s = DIV_STAGES - 1; s >= 0; s--)
        begin
            ready[s] = !valid_reg[s] || ready[s+1];
        end
    end

    always_comb
    begin
        for (int s = 0; s < DIV_STAGES; s++)
        begin
            valid_next[s] = ready[s] ? src_valid[s] : valid_reg[s];
            data_next[s].x = div_steps(src_data[s].x, divisor_x,
                                       (MAG_BITS - s * DIV_STEPS < DIV_STEPS) ?
                                       MAG_BITS - s * DIV_STEPS : DIV_STEPS);
            data_next[s].y = div_steps(src_data[s].y, divisor_y,
                                       (MAG_BITS - s * DIV_STEPS < DIV_STEPS) ?
                                       MAG_BITS - s * DIV_STEPS : DIV_STEPS);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < DIV_STAGES; s++)
        begin
            if (ready[s] && src_valid[s])
            begin
                data_reg[s] <= data_next[s];
            end
        end
    end

    assign in_ready  = ready[0];
    assign out_valid = valid_reg[DIV_STAGES-1];
    assign out_data  = data_reg[DIV_STAGES-1];

endmodule

>>> design/p2h_resolve.sv
// Floor correction, edge test multiplies and hex selection, three register stages.
`timescale 1ns / 1ps

module p2h_resolve import p2h_pkg::*; (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  div_t                       in_data,
    input  logic [REG_BITS-1:0]        cell_w,
    input  logic [REG_BITS-1:0]        cell_h,
    input  logic [DIV_BITS-1:0]        row_pitch,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [COORD_BITS:0] col,
    output logic signed [COORD_BITS:0] row
);

    typedef struct packed {
        logic [COORD_BITS-1:0] qx;
        logic [COORD_BITS-1:0] qy;
        logic [DIV_BITS-1:0]   ry;
        logic [REG_BITS:0]     m;
        logic                  odd;
    } prep_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] qx;
        logic [COORD_BITS-1:0] qy;
        logic [PROD_BITS-1:0]  lhs;
        logic [PROD_BITS-1:0]  rhs;
        logic                  odd;
    } mul_t;

    logic                  prep_valid_reg;
    logic                  mul_valid_reg;
    logic                  out_valid_reg;
    logic                  prep_ready;
    logic                  mul_ready;
    logic                  out_ready_int;
    prep_t                 prep_reg;
    prep_t                 prep_next;
    mul_t                  mul_reg;
    mul_t                  mul_next;
    logic [COORD_BITS:0]   col_reg;
    logic [COORD_BITS:0]   col_next;
    logic [COORD_BITS:0]   row_reg;
    logic [COORD_BITS:0]   row_next;
    logic [COORD_BITS-1:0] qx_mag;
    logic [COORD_BITS-1:0] qy_mag;
    logic [DIV_BITS-1:0]   rx_full;
    logic [REG_BITS-1:0]   rx;
    logic                  lt;
    logic                  col_inc;
    logic                  row_inc;

    assign out_ready_int = !out_valid_reg || out_ready;
    assign mul_ready     = !mul_valid_reg || out_ready_int;
    assign prep_ready    = !prep_valid_reg || mul_ready;
    assign in_ready      = prep_ready;

    always_comb
    begin
        qx_mag = {1'b0, in_data.x.acc};
        qy_mag = {1'b0, in_data.y.acc};
        prep_next.qx = in_data.x.neg ? ~qx_mag : qx_mag;
        prep_next.qy = in_data.y.neg ? ~qy_mag : qy_mag;
        rx_full = in_data.x.neg ?
                  DIV_BITS'(cell_w) - DIV_BITS'(1) - in_data.x.rem : in_data.x.rem;
        rx = rx_full[REG_BITS-1:0];
        prep_next.ry = in_data.y.neg ?
                       row_pitch - DIV_BITS'(1) - in_data.y.rem : in_data.y.rem;
        prep_next.odd = prep_next.qx[0] ^ prep_next.qy[0];
        prep_next.m = prep_next.odd ? ({1'b0, cell_w} + {1'b0, rx}) :
                                      ({cell_w, 1'b0} - {1'b0, rx});
    end

    always_comb
    begin
        mul_next.qx  = prep_reg.qx;
        mul_next.qy  = prep_reg.qy;
        mul_next.odd = prep_reg.odd;
        mul_next.lhs = PROD_BITS'(cell_w) * PROD_BITS'(prep_reg.ry);
        mul_next.rhs = PROD_BITS'(cell_h) * PROD_BITS'(prep_reg.m);
    end

    always_comb
    begin
        lt       = mul_reg.lhs < mul_reg.rhs;
        col_inc  = mul_reg.odd ? lt : !lt;
        row_inc  = !lt;
        col_next = {mul_reg.qx[COORD_BITS-1], mul_reg.qx} + (COORD_BITS + 1)'(col_inc);
        row_next = {mul_reg.qy[COORD_BITS-1], mul_reg.qy} + (COORD_BITS + 1)'(row_inc);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prep_valid_reg <= 1'b0;
            mul_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (prep_ready)
            begin
                prep_valid_reg <= in_valid;
            end
            if (mul_ready)
            begin
                mul_valid_reg <= prep_valid_reg;
            end
            if (out_ready_int)
            begin
                out_valid_reg <= mul_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (prep_ready && in_valid)
        begin
            prep_reg <= prep_next;
        end
        if (mul_ready && prep_valid_reg)
        begin
            mul_reg <= mul_next;
        end
        if (out_ready_int && mul_valid_reg)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign col       = col_reg;
    assign row       = row_reg;

endmodule

>>> design/pixel_to_hex_cell_unit.sv
// Top level of the pixel to hex cell unit: configuration registers and pipeline.
// Maps a signed pixel coordinate to the horizontally aligned hexagon under it, in doubled
// coordinates (hex_col + hex_row is even). pixel_x is floor-divided by cell_width and pixel_y
// by three times cell_height; a register holding zero acts as one. One pixel is taken every
// clock while pixel_stall is low, and each pixel gives exactly one hex, in order. The
// restoring divider resolves three quotient bits per stage and is followed by a
// floor-correction stage, a multiply stage and the output register. Write cell_width
// (index 0) and cell_height (index 1) only while no pixel is in flight; writes to other
// indexes are dropped.
`timescale 1ns / 1ps

module pixel_to_hex_cell_unit import p2h_pkg::*; (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        pixel_valid,
    output logic                        pixel_stall,
    input  logic signed [COORD_BITS-1:0] pixel_x,
    input  logic signed [COORD_BITS-1:0] pixel_y,
    output logic                        hex_valid,
    input  logic                        hex_stall,
    output logic signed [COORD_BITS:0]  hex_col,
    output logic signed [COORD_BITS:0]  hex_row,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [REG_BITS-1:0]         cfg_data
);

    logic [REG_BITS-1:0] cell_width_reg;
    logic [REG_BITS-1:0] cell_width_next;
    logic [REG_BITS-1:0] cell_height_reg;
    logic [REG_BITS-1:0] cell_height_next;
    logic [REG_BITS-1:0] cell_w;
    logic [REG_BITS-1:0] cell_h;
    logic [DIV_BITS-1:0] row_pitch;
    logic                div_in_ready;
    logic                div_out_valid;
    logic                res_in_ready;
    div_t                div_in;
    div_t                div_out;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cell_width_next  = cell_width_reg;
        cell_height_next = cell_height_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_CELL_WIDTH:  cell_width_next = cfg_data;
                REG_CELL_HEIGHT: cell_height_next = cfg_data;
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_width_reg  <= CELL_WIDTH_RESET;
            cell_height_reg <= CELL_HEIGHT_RESET;
        end
        else
        begin
            cell_width_reg  <= cell_width_next;
            cell_height_reg <= cell_height_next;
        end
    end

    assign cell_w    = (cell_width_reg == '0) ? REG_BITS'(1) : cell_width_reg;
    assign cell_h    = (cell_height_reg == '0) ? REG_BITS'(1) : cell_height_reg;
    assign row_pitch = {cell_h, 1'b0} + DIV_BITS'(cell_h);

    always_comb
    begin
        div_in.x.neg = pixel_x[COORD_BITS-1];
        div_in.x.acc = div_in.x.neg ? ~pixel_x[MAG_BITS-1:0] : pixel_x[MAG_BITS-1:0];
        div_in.x.rem = '0;
        div_in.y.neg = pixel_y[COORD_BITS-1];
        div_in.y.acc = div_in.y.neg ? ~pixel_y[MAG_BITS-1:0] : pixel_y[MAG_BITS-1:0];
        div_in.y.rem = '0;
    end

    p2h_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pixel_valid),
        .in_ready  (div_in_ready),
        .in_data   (div_in),
        .divisor_x (DIV_BITS'(cell_w)),
        .divisor_y (row_pitch),
        .out_valid (div_out_valid),
        .out_ready (res_in_ready),
        .out_data  (div_out)
    );

    p2h_resolve u_resolve (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (div_out_valid),
        .in_ready  (res_in_ready),
        .in_data   (div_out),
        .cell_w    (cell_w),
        .cell_h    (cell_h),
        .row_pitch (row_pitch),
        .out_valid (hex_valid),
        .out_ready (!hex_stall),
        .col       (hex_col),
        .row       (hex_row)
    );

    assign pixel_stall = !div_in_ready;

endmodule

>>> design/p2h_checker.sv
// Port-level checks for the pixel to hex cell unit and their bind.
`timescale 1ns / 1ps

module p2h_checker import p2h_pkg::*; (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        pixel_stall,
    input logic                        hex_valid,
    input logic                        hex_stall,
    input logic signed [COORD_BITS:0]  hex_col,
    input logic signed [COORD_BITS:0]  hex_row
);

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        hex_valid && hex_stall |=> hex_valid && $stable(hex_col) && $stable(hex_row))
        else $error("stalled hex transfer changed");

    a_doubled_parity: assert property (@(posedge clk) disable iff (!rst_n)
        hex_valid |-> (hex_col[0] == hex_row[0]))
        else $error("hex_col plus hex_row is odd");

    a_no_stall_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (!hex_valid || !hex_stall) |-> !pixel_stall)
        else $error("pixel stalled while output side can advance");

endmodule

bind pixel_to_hex_cell_unit p2h_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .pixel_stall (pixel_stall),
    .hex_valid   (hex_valid),
    .hex_stall   (hex_stall),
    .hex_col     (hex_col),
    .hex_row     (hex_row)
);

>>> test/testbench.sv
// Self-checking testbench for the pixel to hex cell unit with a scoreboard class.
`timescale 1ns / 1ps

import p2h_pkg::*;

typedef struct packed {
    logic signed [COORD_BITS:0] col;
    logic signed [COORD_BITS:0] row;
} hex_t;

class hex_checker;
    bit [REG_BITS-1:0] cell_width = CELL_WIDTH_RESET;
    bit [REG_BITS-1:0] cell_height = CELL_HEIGHT_RESET;
    hex_t pending_hexes[$];
    int errors;
    int pixels;
    int hexes;

    function void set_reg(logic [CFG_INDEX_BITS-1:0] index, logic [REG_BITS-1:0] data);
        if (index == REG_CELL_WIDTH)
        begin
            cell_width = data;
        end
        else if (index == REG_CELL_HEIGHT)
        begin
            cell_height = data;
        end
    endfunction

    function hex_t locate_hex(logic signed [COORD_BITS-1:0] x,
                              logic signed [COORD_BITS-1:0] y);
        longint w, h, px, py, qx, rx, qy, ry, col, row;
        hex_t hex;
        w = (cell_width == 0) ? 1 : cell_width;
        h = (cell_height == 0) ? 1 : cell_height;
        px = x;
        py = y;
        qx = px / w;
        rx = px % w;
        if (rx < 0)
        begin
            rx += w;
            qx -= 1;
        end
        qy = py / (3 * h);
        ry = py % (3 * h);
        if (ry < 0)
        begin
            ry += 3 * h;
            qy -= 1;
        end
        if (((qx + qy) & 1) == 0)
        begin
            if (w * ry < h * (2 * w - rx))
            begin
                col = qx;
                row = qy;
            end
            else
            begin
                col = qx + 1;
                row = qy + 1;
            end
        end
        else if (w * ry < h * (w + rx))
        begin
            col = qx + 1;
            row = qy;
        end
        else
        begin
            col = qx;
            row = qy + 1;
        end
        hex.col = col[COORD_BITS:0];
        hex.row = row[COORD_BITS:0];
        return hex;
    endfunction

    function void note_pixel(logic signed [COORD_BITS-1:0] x,
                             logic signed [COORD_BITS-1:0] y);
        pending_hexes.insert(pending_hexes.size(), locate_hex(x, y));
        pixels++;
    endfunction

    function void check_hex(logic signed [COORD_BITS:0] col, logic signed [COORD_BITS:0] row);
        hex_t want;
        hexes++;
        if (pending_hexes.size() == 0)
        begin
            $display("%0t: unexpected hex transfer, expected none, got col %0d row %0d",
                     $time, col, row);
            errors++;
            return;
        end
        want = pending_hexes.pop_front();
        if (col !== want.col)
        begin
            $display("%0t: hex_col expected %0d, got %0d", $time, want.col, col);
            errors++;
        end
        if (row !== want.row)
        begin
            $display("%0t: hex_row expected %0d, got %0d", $time, want.row, row);
            errors++;
        end
    endfunction
endclass

module testbench;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_B = 2'd3;
    localparam int NUM_PHASES = 8;
    localparam int RANDOM_PER_PHASE = 48;
    localparam int SQUEEZE_CYCLES = 64;
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT = 60000;

    logic clk = 1'b0;
    logic rst_n;
    logic pixel_valid;
    logic pixel_stall;
    logic signed [COORD_BITS-1:0] pixel_x;
    logic signed [COORD_BITS-1:0] pixel_y;
    logic hex_valid;
    logic hex_stall;
    logic signed [COORD_BITS:0] hex_col;
    logic signed [COORD_BITS:0] hex_row;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [REG_BITS-1:0] cfg_data;

    hex_checker book = new();
    bit steady;
    int squeeze_req;
    int squeeze_seen;
    int squeeze_left;
    int cycles;
    int reg_writes;

    pixel_to_hex_cell_unit dut (
        .clk(clk),
        .rst_n(rst_n),
        .pixel_valid(pixel_valid),
        .pixel_stall(pixel_stall),
        .pixel_x(pixel_x),
        .pixel_y(pixel_y),
        .hex_valid(hex_valid),
        .hex_stall(hex_stall),
        .hex_col(hex_col),
        .hex_row(hex_row),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && hex_valid && !hex_stall)
        begin
            book.check_hex(hex_col, hex_row);
        end
    end

    initial
    begin
        hex_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (squeeze_req != squeeze_seen)
            begin
                squeeze_seen = squeeze_req;
                squeeze_left = SQUEEZE_CYCLES;
            end
            if (squeeze_left > 0)
            begin
                squeeze_left--;
                hex_stall <= 1'b1;
            end
            else
            begin
                hex_stall <= !steady && ($urandom_range(0, 99) < 27);
            end
        end
    end

    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] index, logic [REG_BITS-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        book.set_reg(index, data);
        reg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic send_pixel(logic signed [COORD_BITS-1:0] x, logic signed [COORD_BITS-1:0] y);
        while (!steady && $urandom_range(0, 99) < 27)
        begin
            pixel_valid <= 1'b0;
            @(negedge clk);
        end
        pixel_valid <= 1'b1;
        pixel_x <= x;
        pixel_y <= y;
        do
            @(posedge clk);
        while (pixel_stall);
        book.note_pixel(x, y);
        @(negedge clk);
    endtask

    task automatic drain();
        pixel_valid <= 1'b0;
        while (book.pending_hexes.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic logic signed [COORD_BITS-1:0] pick_coord(longint unit);
        longint v;
        case ($urandom_range(0, 19))
            0: v = $urandom_range(0, 1) ? 32767 : -32768;
            1, 2, 3, 4, 5, 6, 7, 8, 9: v = $urandom;
            10, 11, 12, 13, 14, 15: v = longint'($urandom_range(0, 400)) - 200;
            default: v = (longint'($urandom_range(0, 20)) - 10) * unit
                         + longint'($urandom_range(0, 2)) - 1;
        endcase
        return v[COORD_BITS-1:0];
    endfunction

    initial
    begin
        int wset [NUM_PHASES];
        int hset [NUM_PHASES];
        longint unit_x, unit_y;
        wset = '{26, 1, 4095, 0, 4095, 1, 0, 0};
        hset = '{15, 1, 4095, 0, 1, 4095, 0, 0};
        wset[6] = $urandom_range(1, 4095);
        hset[6] = $urandom_range(1, 4095);
        wset[7] = $urandom_range(2, 40);
        hset[7] = $urandom_range(2, 40);

        rst_n = 1'b0;
        pixel_valid = 1'b0;
        pixel_x = '0;
        pixel_y = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_CELL_WIDTH;
        cfg_data = '0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // tile corners and edges at the reset cell size, plus coordinate extremes
        send_pixel(0, 0);
        send_pixel(-1, -1);
        send_pixel(32767, 32767);
        send_pixel(-32768, -32768);
        send_pixel(32767, -32768);
        send_pixel(-32768, 32767);
        send_pixel(25, 0);
        send_pixel(26, 0);
        send_pixel(25, 44);
        send_pixel(0, 44);
        send_pixel(0, 45);
        send_pixel(51, 44);
        send_pixel(52, 0);
        send_pixel(13, 30);
        send_pixel(39, 30);
        send_pixel(-26, -45);
        send_pixel(-27, -46);
        send_pixel(1, 1);
        send_pixel(13, 15);
        send_pixel(39, 15);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            if (p > 0)
            begin
                drain();
                write_reg(REG_CELL_WIDTH, REG_BITS'(wset[p]));
                write_reg(REG_CELL_HEIGHT, REG_BITS'(hset[p]));
            end
            if (p == 4)
            begin
                write_reg(REG_SPARE_A, REG_BITS'($urandom));
                write_reg(REG_SPARE_B, REG_BITS'($urandom));
            end
            steady = (p == 1);
            if (p == 6)
            begin
                squeeze_req++;
            end
            unit_x = (book.cell_width == 0) ? 1 : book.cell_width;
            unit_y = 3 * ((book.cell_height == 0) ? 1 : book.cell_height);
            for (int i = 0; i < RANDOM_PER_PHASE; i++)
            begin
                send_pixel(pick_coord(unit_x), pick_coord(unit_y));
            end
        end
        steady = 1'b0;
        drain();

        if (book.pending_hexes.size() != 0)
        begin
            $display("%0t: %0d hex results never arrived", $time, book.pending_hexes.size());
            book.errors++;
        end
        $display("Sent %0d pixels and checked %0d hexes across %0d cell size settings,",
                 book.pixels, book.hexes, NUM_PHASES);
        $display("with %0d register writes and one long output hold-off.", reg_writes);
        if (book.errors == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

>>> filelist.f
design/p2h_pkg.sv
design/p2h_divider.sv
design/p2h_resolve.sv
design/pixel_to_hex_cell_unit.sv
design/p2h_checker.sv
test/testbench.sv
